>>> src/cvb_pkg.sv
// ----------------------------------------------------------------------------
// cvb_pkg
// Shared constants, tables and codes for the chord voicing builder.
// ----------------------------------------------------------------------------
package cvb_pkg;

  localparam int MAX_NOTES = 8;
  localparam int NIDX_W    = $clog2(MAX_NOTES);
  localparam int NCNT_W    = $clog2(MAX_NOTES + 1);

  localparam int NOTE_W = 7;
  localparam int PC_W   = 4;
  localparam int OFF_W  = 5;
  localparam int MIDI_W = 8;
  localparam int SCR_W  = 6;
  localparam int NTENS  = 6;

  localparam logic [2:0] KIND_TRIAD = 3'd0;
  localparam logic [2:0] KIND_POWER = 3'd1;
  localparam logic [2:0] KIND_ADD9  = 3'd2;
  localparam logic [2:0] KIND_MAJ7  = 3'd3;
  localparam logic [2:0] KIND_DOM7  = 3'd4;
  localparam logic [2:0] KIND_TENS  = 3'd5;

  localparam logic [6:0] WIDTH_TENS_LIFT  = 7'd33;
  localparam logic [6:0] WIDTH_EVEN_LIFT  = 7'd66;
  localparam logic [6:0] WIDTH_POWER_OCT  = 7'd50;
  localparam logic [6:0] WIDTH_TWO_TENS   = 7'd25;
  localparam logic [6:0] WIDTH_THREE_TENS = 7'd75;

  localparam logic [MIDI_W-1:0] NOTE_CEIL = 8'd96;

  localparam logic [OFF_W-1:0] THIRD_OF [4] = '{5'd4, 5'd3, 5'd4, 5'd3};
  localparam logic [OFF_W-1:0] FIFTH_OF [4] = '{5'd7, 5'd7, 5'd8, 5'd6};

  // Tension candidates in scoring priority: 9, 13, #11, b9, #9, b13
  localparam logic [OFF_W-1:0] TENS_OFF  [NTENS] = '{5'd14, 5'd21, 5'd18, 5'd13, 5'd15, 5'd20};
  localparam logic [PC_W-1:0]  TENS_PC   [NTENS] = '{4'd2, 4'd9, 4'd6, 4'd1, 4'd3, 4'd8};
  localparam logic [SCR_W-1:0] TENS_BASE [NTENS] = '{6'd6, 6'd5, 6'd4, 6'd3, 6'd2, 6'd1};
  localparam logic [NTENS-1:0] TENS_ALT  = 6'b111000;
  localparam logic [NTENS-1:0] TENS_FRESH = 6'b000011;
  // Candidate indexes in ascending interval order
  localparam logic [2:0] TENS_ASC [NTENS] = '{3'd3, 3'd0, 3'd4, 3'd2, 3'd5, 3'd1};

endpackage

>>> src/chord_voicing_builder.sv
// ----------------------------------------------------------------------------
// chord_voicing_builder
// Builds a chord voicing from one request and emits its notes in rising order.
// ----------------------------------------------------------------------------
// Steps: accept, then for tension chords pick up to 3 tensions and gather the
// picked ones over all 6 candidates, then per interval a note step and fold
// steps that drop it an octave at a time and insert it, a close step, then
// the emitted beats, each held while the output stalls.
// Throughput: one request at a time, set by the single fold/insert unit.
// Reset clears the stored context (no previous chord) and the output valid flag.
module chord_voicing_builder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [3:0]                  root_pc_i,
  input  logic [1:0]                  quality_i,
  input  logic [2:0]                  chord_kind_i,
  input  logic [6:0]                  width_pct_i,
  input  logic [6:0]                  octave_base_i,
  input  logic                        forget_context_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [cvb_pkg::NOTE_W-1:0]  note_o,
  output logic [cvb_pkg::PC_W-1:0]    root_out_o,
  output logic                        last_note_o
);
  import cvb_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PICK, S_TENS, S_NOTE, S_FOLD, S_EMIT} state_e;

  state_e state_q;

  logic [PC_W-1:0]   root_q;
  logic [6:0]        wpct_q;
  logic [MIDI_W-1:0] bass_q;
  logic              ctx_q;
  logic [1:0]        wanted_q;
  logic [1:0]        pick_q;
  logic [2:0]        gath_q;
  logic [NTENS-1:0]  used_q;

  logic [OFF_W-1:0]  offs_q [MAX_NOTES];
  logic [NCNT_W-1:0] cnt_q;
  logic [NCNT_W-1:0] k_q;
  logic [MIDI_W-1:0] m_q;

  logic [NOTE_W-1:0] srt_q [MAX_NOTES];
  logic [NCNT_W-1:0] w_q;
  logic [NCNT_W-1:0] e_q;
  logic [11:0]       mask_q;

  logic [11:0]       prev_mask_q;
  logic [PC_W-1:0]   prev_root_q;
  logic              prev_valid_q;

  logic              out_valid_q;
  logic [NOTE_W-1:0] note_q;
  logic [PC_W-1:0]   root_out_q;
  logic              last_q;

  logic              in_acc;
  logic              out_free;
  logic [PC_W-1:0]   root_in;

  logic [SCR_W-1:0]  score [NTENS];
  logic              resolving;
  logic [4:0]        rdiff;
  logic [2:0]        best_idx;
  logic              best_ok;
  logic [SCR_W-1:0]  best_s;

  logic [OFF_W-1:0]  cur_off;
  logic [MIDI_W-1:0] m_new;
  logic [12:0]       fold_prod;
  logic [PC_W-1:0]   pc_fold;

  logic [MAX_NOTES-1:0] lt;
  logic                 dup;
  logic [NOTE_W-1:0]    ins [MAX_NOTES];

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign root_in    = (root_pc_i >= 4'd12) ? root_pc_i - 4'd12 : root_pc_i;

  assign out_valid_o = out_valid_q;
  assign note_o      = note_q;
  assign root_out_o  = root_out_q;
  assign last_note_o = last_q;

  // Tension scores
  always_comb begin
    logic [4:0] pcs;
    logic [PC_W-1:0] pc4;
    rdiff     = 5'({1'b0, root_q}) + 5'd12 - 5'({1'b0, prev_root_q});
    resolving = (rdiff == 5'd5) || (rdiff == 5'd17);
    for (int i = 0; i < NTENS; i++) begin
      pcs = 5'({1'b0, root_q}) + 5'({1'b0, TENS_PC[i]});
      if (pcs >= 5'd12) begin
        pcs = pcs - 5'd12;
      end
      pc4 = pcs[PC_W-1:0];
      score[i] = TENS_BASE[i];
      if (ctx_q) begin
        if (prev_mask_q[pc4]) begin
          score[i] = score[i] + 6'd20;
        end
        if (resolving && TENS_ALT[i]) begin
          score[i] = score[i] + 6'd15;
        end
        if (!resolving && !TENS_ALT[i]) begin
          score[i] = score[i] + 6'd10;
        end
      end else if (TENS_FRESH[i]) begin
        score[i] = score[i] + 6'd8;
      end
    end
  end

  // Highest unused score, first candidate wins ties
  always_comb begin
    best_idx = '0;
    best_ok  = 1'b0;
    best_s   = '0;
    for (int i = 0; i < NTENS; i++) begin
      if (!used_q[i] && (!best_ok || score[i] > best_s)) begin
        best_idx = 3'(i);
        best_ok  = 1'b1;
        best_s   = score[i];
      end
    end
  end

  // Note value of the current interval
  always_comb begin
    cur_off = offs_q[k_q[NIDX_W-1:0]];
    m_new = bass_q + MIDI_W'(cur_off);
    if (cur_off >= 5'd13 && wpct_q >= WIDTH_TENS_LIFT) begin
      m_new = m_new + 8'd12;
    end
    if (k_q >= NCNT_W'(2) && !k_q[0] && wpct_q >= WIDTH_EVEN_LIFT) begin
      m_new = m_new + 8'd12;
    end
  end

  // Pitch class of the folded note: divide by 12 through multiply by 43/512
  always_comb begin
    fold_prod = 13'(m_q[NOTE_W-1:0]) * 13'd43;
    pc_fold   = PC_W'(m_q[NOTE_W-1:0] - {fold_prod[12:9], 3'b000}
                      - {1'b0, fold_prod[12:9], 2'b00});
  end

  // Sorted insertion of the folded note
  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < MAX_NOTES; i++) begin
      lt[i] = (NCNT_W'(i) < w_q) && (srt_q[i] < m_q[NOTE_W-1:0]);
      if ((NCNT_W'(i) < w_q) && (srt_q[i] == m_q[NOTE_W-1:0])) begin
        dup = 1'b1;
      end
    end
    ins[0] = lt[0] ? srt_q[0] : m_q[NOTE_W-1:0];
    for (int i = 1; i < MAX_NOTES; i++) begin
      if (lt[i]) begin
        ins[i] = srt_q[i];
      end else if (lt[i-1]) begin
        ins[i] = m_q[NOTE_W-1:0];
      end else begin
        ins[i] = srt_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      prev_mask_q  <= '0;
      prev_root_q  <= '0;
      prev_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
      k_q          <= '0;
      w_q          <= '0;
      e_q          <= '0;
      used_q       <= '0;
      pick_q       <= '0;
      gath_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            root_q   <= root_in;
            wpct_q   <= width_pct_i;
            bass_q   <= MIDI_W'(octave_base_i) + MIDI_W'(root_in);
            ctx_q    <= prev_valid_q && !forget_context_i;
            wanted_q <= 2'd1 + 2'(width_pct_i >= WIDTH_TWO_TENS)
                        + 2'(width_pct_i >= WIDTH_THREE_TENS);
            pick_q   <= '0;
            gath_q   <= '0;
            used_q   <= '0;
            k_q      <= '0;
            w_q      <= '0;
            e_q      <= '0;
            mask_q   <= '0;
            offs_q[0] <= 5'd0;
            if (chord_kind_i == KIND_POWER) begin
              offs_q[1] <= 5'd7;
              offs_q[2] <= 5'd12;
              cnt_q     <= (width_pct_i >= WIDTH_POWER_OCT) ? NCNT_W'(3) : NCNT_W'(2);
              state_q   <= S_NOTE;
            end else begin
              offs_q[1] <= THIRD_OF[quality_i];
              offs_q[2] <= FIFTH_OF[quality_i];
              cnt_q     <= NCNT_W'(4);
              state_q   <= S_NOTE;
              case (chord_kind_i)
                KIND_ADD9: offs_q[3] <= 5'd14;
                KIND_MAJ7: offs_q[3] <= 5'd11;
                KIND_DOM7: offs_q[3] <= 5'd10;
                KIND_TENS: begin
                  offs_q[3] <= 5'd10;
                  state_q   <= S_PICK;
                end
                default: cnt_q <= NCNT_W'(3);
              endcase
            end
          end
        end
        S_PICK: begin
          if (best_ok) begin
            used_q[best_idx] <= 1'b1;
          end
          pick_q <= pick_q + 2'd1;
          if (pick_q + 2'd1 == wanted_q || !best_ok) begin
            state_q <= S_TENS;
          end
        end
        S_TENS: begin
          if (used_q[TENS_ASC[gath_q]] && cnt_q < NCNT_W'(MAX_NOTES)) begin
            offs_q[cnt_q[NIDX_W-1:0]] <= TENS_OFF[TENS_ASC[gath_q]];
            cnt_q <= cnt_q + NCNT_W'(1);
          end
          gath_q <= gath_q + 3'd1;
          if (gath_q == 3'(NTENS - 1)) begin
            state_q <= S_NOTE;
          end
        end
        S_NOTE: begin
          if (k_q == cnt_q) begin
            prev_mask_q  <= mask_q;
            prev_root_q  <= root_q;
            prev_valid_q <= (w_q != '0);
            state_q      <= S_EMIT;
          end else begin
            m_q     <= m_new;
            state_q <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (m_q > NOTE_CEIL) begin
            m_q <= m_q - 8'd12;
          end else begin
            if (!dup) begin
              for (int i = 0; i < MAX_NOTES; i++) begin
                srt_q[i] <= ins[i];
              end
              w_q <= w_q + NCNT_W'(1);
            end
            mask_q[pc_fold] <= 1'b1;
            k_q     <= k_q + NCNT_W'(1);
            state_q <= S_NOTE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            note_q      <= srt_q[e_q[NIDX_W-1:0]];
            root_out_q  <= root_q;
            last_q      <= (e_q + NCNT_W'(1) == w_q);
            e_q         <= e_q + NCNT_W'(1);
            if (e_q + NCNT_W'(1) == w_q) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> bench/chord_voicing_builder_test.sv
// ----------------------------------------------------------------------------
// chord_voicing_builder_test
// Drives chord requests into the voicing builder through the valid/stall
// channel and checks every emitted note beat against a voicing predictor
// that keeps its own copy of the previous-chord context. A directed set
// covers field extremes, every chord kind and quality, out-of-range roots,
// folding of high notes and context handling; a random set follows, with
// bursty input, a patterned output stall, one long output hold-off and one
// full drain of pending notes.
// ----------------------------------------------------------------------------
module chord_voicing_builder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cvb_pkg::*;

  localparam logic [1:0] QUAL_MAJOR = 2'd0;
  localparam logic [1:0] QUAL_MINOR = 2'd1;
  localparam logic [1:0] QUAL_AUG   = 2'd2;
  localparam logic [1:0] QUAL_DIM   = 2'd3;

  localparam int RANDOM_CHORDS = 350;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 100;

  typedef struct packed {
    logic [3:0] root;
    logic [1:0] quality;
    logic [2:0] kind;
    logic [6:0] width;
    logic [6:0] base;
    logic       forget;
  } chord_req_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [PC_W-1:0]   root;
    logic              last;
  } note_beat_t;

  class voicing_scoreboard;
    note_beat_t  expected_notes[$];
    bit   [11:0] ctx_mask  = '0;
    bit   [3:0]  ctx_root  = '0;
    bit          ctx_valid = 1'b0;
    int          errors    = 0;

    function void note_request(chord_req_t r);
      int root, wpct, bass, n, w, m, v, j, wanted, best, bs, tn;
      int offs[12];
      int notes[12];
      int score[6];
      int cand[6];
      int picks[3];
      bit alt[6];
      bit used[6];
      bit ctx, resolving;
      bit [11:0] mask;
      note_beat_t beat;
      root = int'(r.root) % 12;
      wpct = int'(r.width);
      ctx  = ctx_valid && !r.forget;
      if (r.kind == KIND_POWER) begin
        offs[0] = 0;
        offs[1] = 7;
        n = 2;
        if (wpct >= 50) begin
          offs[2] = 12;
          n = 3;
        end
      end else begin
        offs[0] = 0;
        offs[1] = (r.quality == QUAL_MAJOR || r.quality == QUAL_AUG) ? 4 : 3;
        case (r.quality)
          QUAL_AUG: offs[2] = 8;
          QUAL_DIM: offs[2] = 6;
          default:  offs[2] = 7;
        endcase
        n = 3;
        case (r.kind)
          KIND_ADD9: begin offs[3] = 14; n = 4; end
          KIND_MAJ7: begin offs[3] = 11; n = 4; end
          KIND_DOM7: begin offs[3] = 10; n = 4; end
          KIND_TENS: begin
            offs[3] = 10;
            n = 4;
            resolving = ctx && (((root + 12 - int'(ctx_root) % 12) % 12) == 5);
            for (int i = 0; i < 6; i++) begin
              case (i)
                0: begin cand[i] = 14; score[i] = 6; alt[i] = 1'b0; end
                1: begin cand[i] = 21; score[i] = 5; alt[i] = 1'b0; end
                2: begin cand[i] = 18; score[i] = 4; alt[i] = 1'b0; end
                3: begin cand[i] = 13; score[i] = 3; alt[i] = 1'b1; end
                4: begin cand[i] = 15; score[i] = 2; alt[i] = 1'b1; end
                default: begin cand[i] = 20; score[i] = 1; alt[i] = 1'b1; end
              endcase
              used[i] = 1'b0;
              if (ctx) begin
                if (ctx_mask[(root + cand[i]) % 12]) score[i] += 20;
                if (resolving && alt[i]) score[i] += 15;
                if (!resolving && !alt[i]) score[i] += 10;
              end else if (cand[i] == 14 || cand[i] == 21) begin
                score[i] += 8;
              end
            end
            wanted = 1 + (wpct >= 25) + (wpct >= 75);
            for (tn = 0; tn < wanted; tn++) begin
              best = 0;
              bs = -1;
              for (int i = 0; i < 6; i++)
                if (!used[i] && score[i] > bs) begin
                  bs = score[i];
                  best = i;
                end
              used[best] = 1'b1;
              picks[tn] = cand[best];
            end
            for (int i = 1; i < wanted; i++) begin
              v = picks[i];
              j = i;
              while (j > 0 && picks[j - 1] > v) begin
                picks[j] = picks[j - 1];
                j--;
              end
              picks[j] = v;
            end
            for (int i = 0; i < wanted; i++) begin
              offs[n] = picks[i];
              n++;
            end
          end
          default: ;
        endcase
      end

      bass = int'(r.base) + root;
      for (int k = 0; k < n; k++) begin
        m = bass + offs[k];
        if (offs[k] >= 13 && wpct >= 33) m += 12;
        if (k >= 2 && k % 2 == 0 && wpct >= 66) m += 12;
        while (m > 96) m -= 12;
        notes[k] = m;
      end
      for (int k = 1; k < n; k++) begin
        v = notes[k];
        j = k;
        while (j > 0 && notes[j - 1] > v) begin
          notes[j] = notes[j - 1];
          j--;
        end
        notes[j] = v;
      end
      w = 0;
      for (int k = 0; k < n; k++)
        if (w == 0 || notes[w - 1] != notes[k]) begin
          notes[w] = notes[k];
          w++;
        end

      mask = '0;
      for (int k = 0; k < w; k++) begin
        beat.note = notes[k][NOTE_W-1:0];
        beat.root = root[PC_W-1:0];
        beat.last = (k + 1 == w);
        expected_notes.push_back(beat);
        mask[notes[k] % 12] = 1'b1;
      end
      ctx_mask  = mask;
      ctx_root  = root[3:0];
      ctx_valid = (w > 0);
    endfunction

    function void check_note(logic [NOTE_W-1:0] note, logic [PC_W-1:0] root, logic last);
      note_beat_t exp_beat;
      if (expected_notes.size() == 0) begin
        $display("%0t: unexpected beat note=%0d root=%0d last=%0b", $time, note, root, last);
        errors++;
        return;
      end
      exp_beat = expected_notes.pop_front();
      if (note !== exp_beat.note) begin
        $display("%0t: note expected %0d actual %0d", $time, exp_beat.note, note);
        errors++;
      end
      if (root !== exp_beat.root) begin
        $display("%0t: root_out expected %0d actual %0d", $time, exp_beat.root, root);
        errors++;
      end
      if (last !== exp_beat.last) begin
        $display("%0t: last_note expected %0b actual %0b", $time, exp_beat.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni           = 1'b0;
  logic                 in_valid_i       = 1'b0;
  logic                 in_stall_o;
  logic [3:0]           root_pc_i        = '0;
  logic [1:0]           quality_i        = '0;
  logic [2:0]           chord_kind_i     = '0;
  logic [6:0]           width_pct_i      = '0;
  logic [6:0]           octave_base_i    = '0;
  logic                 forget_context_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i      = 1'b0;
  logic [NOTE_W-1:0]    note_o;
  logic [PC_W-1:0]      root_out_o;
  logic                 last_note_o;

  voicing_scoreboard sb = new();
  bit hold_out = 1'b0;
  int idle_cycles = 0;

  chord_voicing_builder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .root_pc_i        (root_pc_i),
    .quality_i        (quality_i),
    .chord_kind_i     (chord_kind_i),
    .width_pct_i      (width_pct_i),
    .octave_base_i    (octave_base_i),
    .forget_context_i (forget_context_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .note_o           (note_o),
    .root_out_o       (root_out_o),
    .last_note_o      (last_note_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    chord_req_t req;
    bit moved;
    moved = 1'b0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      req = '{root_pc_i, quality_i, chord_kind_i, width_pct_i, octave_base_i,
              forget_context_i};
      sb.note_request(req);
      moved = 1'b1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_note(note_o, root_out_o, last_note_o);
      moved = 1'b1;
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("chord_voicing_builder test failed");
    $finish;
  end

  // output side: random stall modes, plus one long hold-off on request
  initial begin
    int phase_left;
    int mode;
    phase_left = 0;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_out = 1'b0;
      end else begin
        if (phase_left == 0) begin
          mode = $urandom_range(0, 3);
          phase_left = $urandom_range(8, 80);
        end
        phase_left--;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  task automatic send_chord(input chord_req_t r);
    in_valid_i       <= 1'b1;
    root_pc_i        <= r.root;
    quality_i        <= r.quality;
    chord_kind_i     <= r.kind;
    width_pct_i      <= r.width;
    octave_base_i    <= r.base;
    forget_context_i <= r.forget;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic pause_input(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_notes();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_notes.size() != 0);
  endtask

  initial begin
    chord_req_t directed[$];
    chord_req_t r;
    int sent;
    int burst;
    int gap;
    int last_root;
    int pick;

    directed = '{
      '{4'd0,  QUAL_MAJOR, KIND_TRIAD, 7'd0,   7'd60,  1'b0},
      '{4'd0,  QUAL_MAJOR, KIND_TENS,  7'd0,   7'd60,  1'b0},
      '{4'd0,  QUAL_MAJOR, KIND_TENS,  7'd0,   7'd60,  1'b1},
      '{4'd7,  QUAL_MAJOR, KIND_DOM7,  7'd50,  7'd48,  1'b0},
      '{4'd0,  QUAL_MAJOR, KIND_TENS,  7'd100, 7'd48,  1'b0},
      '{4'd5,  QUAL_MINOR, KIND_TENS,  7'd25,  7'd36,  1'b0},
      '{4'd10, QUAL_AUG,   KIND_TENS,  7'd75,  7'd72,  1'b0},
      '{4'd3,  QUAL_DIM,   KIND_TENS,  7'd127, 7'd96,  1'b0},
      '{4'd15, QUAL_MINOR, KIND_POWER, 7'd49,  7'd60,  1'b0},
      '{4'd12, QUAL_MAJOR, KIND_POWER, 7'd50,  7'd0,   1'b0},
      '{4'd13, QUAL_AUG,   KIND_POWER, 7'd127, 7'd127, 1'b0},
      '{4'd14, QUAL_DIM,   KIND_ADD9,  7'd32,  7'd24,  1'b0},
      '{4'd11, QUAL_MINOR, KIND_ADD9,  7'd33,  7'd84,  1'b0},
      '{4'd9,  QUAL_AUG,   KIND_MAJ7,  7'd65,  7'd96,  1'b0},
      '{4'd8,  QUAL_DIM,   KIND_MAJ7,  7'd66,  7'd12,  1'b0},
      '{4'd6,  QUAL_MAJOR, KIND_DOM7,  7'd100, 7'd127, 1'b0},
      '{4'd4,  QUAL_MINOR, 3'd6,       7'd0,   7'd60,  1'b0},
      '{4'd2,  QUAL_AUG,   3'd7,       7'd127, 7'd0,   1'b1},
      '{4'd1,  QUAL_DIM,   KIND_TRIAD, 7'd74,  7'd96,  1'b0},
      '{4'd0,  QUAL_MAJOR, KIND_TENS,  7'd24,  7'd0,   1'b1},
      '{4'd5,  QUAL_MAJOR, KIND_TENS,  7'd126, 7'd1,   1'b0},
      '{4'd10, QUAL_MINOR, KIND_TENS,  7'd85,  7'd127, 1'b0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_chord(directed[i]);
      if ($urandom_range(0, 2) == 0) pause_input($urandom_range(1, 30));
    end

    sent = 0;
    last_root = 10;
    while (sent < RANDOM_CHORDS) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < RANDOM_CHORDS; b++) begin
        if ($urandom_range(0, 7) == 0) r.root = 4'($urandom_range(12, 15));
        else if ($urandom_range(0, 3) == 0) r.root = 4'((last_root + 5) % 12);
        else r.root = 4'($urandom_range(0, 11));
        r.quality = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 15);
        r.kind = (pick < 6) ? KIND_TENS : 3'((pick - 6) % 8);
        r.width = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
                                               : 7'($urandom_range(0, 100));
        r.base = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(97, 127))
                                              : 7'($urandom_range(0, 96));
        r.forget = ($urandom_range(0, 7) == 0);
        last_root = int'(r.root) % 12;
        send_chord(r);
        sent++;
        if (sent == 100) hold_out = 1'b1;
        if (sent == 200) drain_notes();
      end
      if (!hold_out) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        if (gap > 0) pause_input(gap);
      end
    end

    drain_notes();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_notes.size() == 0) begin
      $display("chord_voicing_builder test passed");
    end else begin
      $display("chord_voicing_builder test failed");
    end
    $finish;
  end

endmodule

>>> chord_voicing_builder.f
src/cvb_pkg.sv
src/chord_voicing_builder.sv
bench/chord_voicing_builder_test.sv
